[hdl/sprpe_pkg.sv]
// shared types and constants for the sprite row plane encoder
package sprpe_pkg;

  localparam int ROW_PIXELS = 16;
  localparam int HALF_PIXELS = ROW_PIXELS / 2;
  localparam int PIX_BITS = 5;
  localparam logic [7:0] MIX_FLAG = 8'd64;
  localparam logic [7:0] BLANK_MONO = 8'd255;

  typedef logic [PIX_BITS-1:0] pixel_t;
  typedef logic [ROW_PIXELS-1:0][PIX_BITS-1:0] row_t;
  typedef logic [ROW_PIXELS-1:0] mask_t;

  // palette slots and row classification handed between stages
  typedef struct packed {
    pixel_t c0;
    pixel_t c1;
    pixel_t c2;
    logic   any;
    logic   has2;
    logic   many;
    logic   too;
  } pal_t;

  // pixel equals colour plus one, compared at six bits
  function automatic logic pix_is(input pixel_t p, input pixel_t c);
    return ({1'b0, p} == ({1'b0, c} + 6'd1));
  endfunction

endpackage

[hdl/sprpe_gather.sv]
// merge of per-pixel first-appearance flags into the first three colours
module sprpe_gather
  import sprpe_pkg::*;
(
  input  row_t  px,
  input  mask_t first,
  output pal_t  pal
);

  mask_t  rest;
  pixel_t sel [3];
  logic   hit [3];

  always_comb begin
    rest = first;
    for (int k = 0; k < 3; k++) begin
      sel[k] = '0;
      hit[k] = 1'b0;
      for (int i = 0; i < ROW_PIXELS; i++) begin
        if (rest[i] && !hit[k]) begin
          hit[k] = 1'b1;
          sel[k] = px[i];
        end
      end
      // drop the lowest set flag
      rest = rest & (rest - mask_t'(1));
    end
    pal.any  = hit[0];
    pal.c0   = hit[0] ? sel[0] - pixel_t'(1) : '0;
    pal.c1   = hit[1] ? sel[1] - pixel_t'(1) : pal.c0;
    pal.c2   = hit[2] ? sel[2] - pixel_t'(1) : '0;
    pal.has2 = hit[2];
    pal.many = ($countones(first) > 3);
    pal.too  = pal.many;
  end

endmodule

[hdl/sprpe_fix.sv]
// mixed colour search and swap into the third slot; flags too many colours if absent
module sprpe_fix
  import sprpe_pkg::*;
(
  input  row_t px,
  input  logic mode,
  input  pal_t pal_in,
  output pal_t pal_out
);

  pixel_t mix;
  logic   found;

  always_comb begin
    mix   = pal_in.c0 | pal_in.c1 | pal_in.c2;
    found = 1'b0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      if (pix_is(px[i], mix)) found = 1'b1;
    end
    pal_out = pal_in;
    if (mode && pal_in.has2) begin
      if (found) begin
        if (mix == pal_in.c0) pal_out.c0 = pal_in.c2;
        else if (mix == pal_in.c1) pal_out.c1 = pal_in.c2;
        pal_out.c2 = mix;
      end else begin
        pal_out.too = 1'b1;
      end
    end
  end

endmodule

[hdl/sprpe_lane.sv]
// one pixel lane: plane selects against the final palette
module sprpe_lane
  import sprpe_pkg::*;
(
  input  pixel_t p,
  input  pal_t   pal,
  output logic   s0,
  output logic   s1,
  output logic   m2,
  output logic   occ
);

  assign m2  = pal.has2 && pix_is(p, pal.c2);
  assign s0  = pix_is(p, pal.c0) || m2;
  assign s1  = pix_is(p, pal.c1) || m2;
  assign occ = (p != '0);

endmodule

[hdl/sprite_row_plane_encoder_mirrored_core.sv]
// top level of the sprite row plane encoder with mirrored planes
//
// one input transfer carries a 16-pixel sprite row (5 bits a pixel, 0 is
// transparent) and the encoding mode in s_tuser; one output transfer carries
// the four plane bytes, the four mirrored plane bytes, the two colour bytes
// and the too-many-colors flag
// pipeline: first-appearance lanes, palette merge, mixed colour fix, plane
// lanes into the output register; a row passes the stage 1, 2 and 3 registers
// and the output register, and a new row is accepted on every advancing cycle
// every pipeline stage advances together; only a full output register that
// the receiver does not take holds the pipeline, and s_tready then drops in
// the same cycle, so nothing is dropped or repeated
// reset clears all valid flags; no state is carried between rows
module sprite_row_plane_encoder_mirrored_core
  import sprpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // left_pixels[39:0], right_pixels[79:40]
  input  logic        s_tuser,  // color_mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // plane_a[7:0], plane_b[15:8], plane_c[23:16], plane_d[31:24],
  // mirror_a[39:32], mirror_b[47:40], mirror_c[55:48], mirror_d[63:56],
  // color_low[71:64], color_high[79:72], too_many_colors[80], zeros above
  output logic [87:0] m_tdata
);

  // global advance: stall only when the result waits and is not taken
  logic adv;
  assign adv      = !(m_tvalid && !m_tready);
  assign s_tready = adv;

  // unpack the row, pixel 0 in the lowest bits of the left half
  row_t px_in;
  always_comb begin
    for (int i = 0; i < HALF_PIXELS; i++) begin
      px_in[i]               = s_tdata[PIX_BITS*i +: PIX_BITS];
      px_in[i + HALF_PIXELS] = s_tdata[PIX_BITS*(i + HALF_PIXELS) +: PIX_BITS];
    end
  end

  // first-appearance lanes: a non-transparent pixel with no equal pixel before it
  mask_t first_in;
  always_comb begin
    for (int i = 0; i < ROW_PIXELS; i++) begin
      first_in[i] = (px_in[i] != '0);
      for (int j = 0; j < i; j++) begin
        if (px_in[j] == px_in[i]) first_in[i] = 1'b0;
      end
    end
  end

  // stage 1 registers
  logic  v1;
  row_t  px1;
  logic  mode1;
  mask_t first1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1    <= px_in;
      mode1  <= s_tuser;
      first1 <= first_in;
    end
  end

  // merge of the lanes into the first three colours
  pal_t pal_gather;
  sprpe_gather u_gather (
    .px    (px1),
    .first (first1),
    .pal   (pal_gather)
  );

  // stage 2 registers
  logic v2;
  row_t px2;
  logic mode2;
  pal_t pal2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px2   <= px1;
      mode2 <= mode1;
      pal2  <= pal_gather;
    end
  end

  // mixed colour lookup and slot swap
  pal_t pal_fixed;
  sprpe_fix u_fix (
    .px      (px2),
    .mode    (mode2),
    .pal_in  (pal2),
    .pal_out (pal_fixed)
  );

  // stage 3 registers
  logic v3;
  row_t px3;
  logic mode3;
  pal_t pal3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px3   <= px2;
      mode3 <= mode2;
      pal3  <= pal_fixed;
    end
  end

  // plane lanes, one per pixel
  mask_t s0, s1, m2, occ;
  for (genvar g = 0; g < ROW_PIXELS; g++) begin : g_lane
    sprpe_lane u_lane (
      .p   (px3[g]),
      .pal (pal3),
      .s0  (s0[g]),
      .s1  (s1[g]),
      .m2  (m2[g]),
      .occ (occ[g])
    );
  end

  // assemble bytes; msb of plane_a and plane_b is the leftmost pixel of its half
  logic [7:0] plane_a, plane_b, plane_c, plane_d;
  logic [7:0] mirror_a, mirror_b, mirror_c, mirror_d;
  logic [7:0] color_low, color_high;
  logic       too_many_colors;

  always_comb begin
    for (int j = 0; j < HALF_PIXELS; j++) begin
      if (mode3) begin
        plane_a[j]  = s0[HALF_PIXELS - 1 - j];
        plane_b[j]  = s0[ROW_PIXELS - 1 - j];
        plane_c[j]  = s1[HALF_PIXELS - 1 - j];
        plane_d[j]  = s1[ROW_PIXELS - 1 - j];
        mirror_a[j] = s0[HALF_PIXELS + j];
        mirror_b[j] = s0[j];
        mirror_c[j] = s1[HALF_PIXELS + j];
        mirror_d[j] = s1[j];
      end else begin
        plane_a[j]  = occ[HALF_PIXELS - 1 - j];
        plane_b[j]  = occ[ROW_PIXELS - 1 - j];
        plane_c[j]  = occ[HALF_PIXELS + j];
        plane_d[j]  = occ[j];
        mirror_a[j] = 1'b0;
        mirror_b[j] = 1'b0;
        mirror_c[j] = 1'b0;
        mirror_d[j] = 1'b0;
      end
    end
    if (mode3) begin
      color_low       = {3'b000, pal3.c0};
      color_high      = {3'b000, pal3.c1} | ((|m2) ? MIX_FLAG : 8'd0);
      too_many_colors = pal3.too;
    end else begin
      // first pixel minus one, wrapping for a blank row
      color_low       = pal3.any ? {3'b000, pal3.c0} : BLANK_MONO;
      color_high      = 8'd0;
      too_many_colors = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'd0, too_many_colors, color_high, color_low,
                  mirror_d, mirror_c, mirror_b, mirror_a,
                  plane_d, plane_c, plane_b, plane_a};
    end
  end

`ifndef ASSERT_OFF
  // a resolved multicolour palette keeps the mixed colour in slot 2,
  // which covers every bit of the first two colours
  a_mix_slot: assert property (@(posedge clk) disable iff (rst)
    (v3 && mode3 && pal3.has2 && !pal3.too) |->
      (((pal3.c0 | pal3.c1) & ~pal3.c2) == '0))
    else $error("slot 2 does not cover the first two colours");

  // with two colours or fewer the row always encodes exactly
  a_few_ok: assert property (@(posedge clk) disable iff (rst)
    (v3 && mode3 && !pal3.has2) |-> !pal3.too)
    else $error("row with at most two colours flagged");

  // more than three colours implies a third slot was gathered
  a_many_has2: assert property (@(posedge clk) disable iff (rst)
    (v2 && pal2.many) |-> pal2.has2)
    else $error("colour count inconsistent with gathered slots");

  // an item in stage 1 moves on to stage 2 on every advancing cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (adv && v1) |=> v2)
    else $error("pipeline lost an item");
`endif

endmodule

[bench/tb_sprite_row_plane_encoder_mirrored_core.sv]
// self-checking testbench for the sprite row plane encoder with mirrored planes
module tb_sprite_row_plane_encoder_mirrored_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sprpe_pkg::*;

  localparam logic MODE_MONO = 1'b0;
  localparam logic MODE_MULTI = 1'b1;
  localparam int N_RANDOM = 880;
  localparam int CALM_FIRST = 300;  // random rows in this window see no idling
  localparam int CALM_LAST = 450;
  localparam int IDLE_PCT = 14;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 10;

  // one encoded row laid out exactly as m_tdata, msb first
  typedef struct packed {
    logic [6:0] pad;
    logic       too_many;
    logic [7:0] color_high;
    logic [7:0] color_low;
    logic [7:0] mirror_d;
    logic [7:0] mirror_c;
    logic [7:0] mirror_b;
    logic [7:0] mirror_a;
    logic [7:0] plane_d;
    logic [7:0] plane_c;
    logic [7:0] plane_b;
    logic [7:0] plane_a;
  } row_code_t;

  // directed row; when known is set the code is typed in, all four planes and
  // all four mirrors sharing one value each
  typedef struct packed {
    logic [39:0] left;
    logic [39:0] right;
    logic        mode;
    logic        known;
    logic [7:0]  planes;
    logic [7:0]  mirrors;
    logic [7:0]  clo;
    logic [7:0]  chi;
    logic        too;
  } probe_t;

  localparam int N_PROBES = 24;

  // pixel 0 (and pixel 8) sits in the lowest five bits of each half
  probe_t probes [N_PROBES] = '{
    // blank rows and solid rows, code read off directly
    '{40'd0, 40'd0, MODE_MONO, 1'b1, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0},
    '{40'd0, 40'd0, MODE_MULTI, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{8{5'd31}}, {8{5'd31}}, MODE_MONO, 1'b1, 8'hff, 8'h00, 8'h1e, 8'h00, 1'b0},
    '{{8{5'd31}}, {8{5'd31}}, MODE_MULTI, 1'b1, 8'hff, 8'hff, 8'h1e, 8'h1e, 1'b0},
    '{{8{5'd1}}, {8{5'd1}}, MODE_MULTI, 1'b1, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0},
    '{{8{5'd1}}, {8{5'd1}}, MODE_MONO, 1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0},
    // single pixels at the row ends, for bit order and mirroring
    '{{35'd0, 5'd9}, 40'd0, MODE_MONO, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{40'd0, {5'd7, 35'd0}, MODE_MONO, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{40'd0, {5'd20, 35'd0}, MODE_MULTI, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // two colours
    '{{4{5'd2, 5'd1}}, {4{5'd1, 5'd2}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // two colours, one of them colour 0: the empty third slot must not match
    '{{4{5'd4, 5'd1}}, {4{5'd0, 5'd4}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // three colours, mixed colour gathered third, first and second
    '{{2{5'd0, 5'd4, 5'd3, 5'd2}}, {4{5'd4, 5'd2}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{2{5'd3, 5'd2, 5'd0, 5'd4}}, {8{5'd3}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{2{5'd0, 5'd5, 5'd6, 5'd2}}, {4{5'd6, 5'd0}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // three colours and none of them is the or of all three
    '{{2{5'd5, 5'd0, 5'd3, 5'd2}}, 40'd0, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // four colours, mixed colour gathered fourth and then third
    '{{2{5'd8, 5'd5, 5'd3, 5'd2}}, {4{5'd0, 5'd8}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{2{5'd9, 5'd4, 5'd3, 5'd2}}, 40'd0, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // sixteen distinct colours
    '{{5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1},
      {5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // pixel values above 16 behave as ordinary colours
    '{{5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17},
      {5'd17, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17},
      {5'd17, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25}, MODE_MONO,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{2{5'd0, 5'd18, 5'd2, 5'd17}}, {2{5'd18, 5'd18, 5'd0, 5'd0}}, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{{8{5'd31}}, 40'd0, MODE_MULTI, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    // alternating bit patterns
    '{40'haaaaaaaaaa, 40'h5555555555, MODE_MULTI,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
    '{40'haaaaaaaaaa, 40'h5555555555, MODE_MONO,
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}
  };

  string field_name [12] = '{"plane_a", "plane_b", "plane_c", "plane_d",
                             "mirror_a", "mirror_b", "mirror_c", "mirror_d",
                             "color_low", "color_high", "too_many_colors", "pad"};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;  // left_pixels[39:0], right_pixels[79:40]
  logic        s_tuser = 1'b0;  // color_mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // plane_a..d, mirror_a..d, color_low, color_high bytes from bit 0 up,
  // too_many_colors[80], zeros above
  logic [87:0] m_tdata;

  // the row on s_tdata carries a typed-in code when probe_known is set
  logic        probe_known = 1'b0;
  row_code_t   probe_code = '0;
  bit          calm = 1'b0;

  row_code_t   pending_codes [$];
  int          n_rows = 0;
  int          n_multi = 0;
  int          n_flagged = 0;
  int          n_mixed = 0;
  int          n_codes = 0;
  int          n_errors = 0;
  int          n_reported = 0;
  int          idle_cycles = 0;

  sprite_row_plane_encoder_mirrored_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // expected code of one row
  function automatic row_code_t encode_row(input logic [79:0] pix, input logic mode);
    row_code_t   r;
    pixel_t      px [ROW_PIXELS];
    int unsigned pal [ROW_PIXELS];
    int unsigned n_col, first, mix, slot, tmp;
    int          i, e, f, k;
    int          pos [4];
    logic [7:0]  lo [4];
    logic [7:0]  hi [4];
    bit          seen, has2, found, mixed, too, m2;
    r = '0;
    n_col = 0;
    first = 0;
    slot = 0;
    found = 1'b0;
    mixed = 1'b0;
    for (i = 0; i < ROW_PIXELS; i++) begin
      px[i] = pix[PIX_BITS*i +: PIX_BITS];
      pal[i] = 0;
    end
    if (mode == MODE_MONO) begin
      for (i = ROW_PIXELS - 1; i >= 0; i--) begin
        if (px[i] != 0) first = px[i];
      end
      for (e = 0; e < HALF_PIXELS; e++) begin
        r.plane_a[7-e] = (px[e] != 0);
        r.plane_b[7-e] = (px[e+HALF_PIXELS] != 0);
        r.plane_c[7-e] = (px[ROW_PIXELS-1-e] != 0);
        r.plane_d[7-e] = (px[HALF_PIXELS-1-e] != 0);
      end
      r.color_low = (first == 0) ? BLANK_MONO : 8'(first - 1);
    end else begin
      // colours in order of first appearance
      for (i = 0; i < ROW_PIXELS; i++) begin
        if (px[i] != 0) begin
          seen = 1'b0;
          for (f = 0; f < n_col; f++) begin
            if (pal[f] + 1 == px[i]) seen = 1'b1;
          end
          if (!seen) begin
            pal[n_col] = px[i] - 1;
            n_col++;
          end
        end
      end
      too = (n_col > 3);
      has2 = (n_col > 2);
      if (n_col < 2) pal[1] = pal[0];
      if (has2) begin
        // last colour equal to the or of the first three goes to slot 2
        mix = pal[0] | pal[1] | pal[2];
        for (f = 0; f < n_col; f++) begin
          if (pal[f] == mix) begin
            found = 1'b1;
            slot = f;
          end
        end
        if (!found) begin
          too = 1'b1;
        end else begin
          tmp = pal[2];
          pal[2] = pal[slot];
          pal[slot] = tmp;
        end
      end
      for (k = 0; k < 4; k++) begin
        lo[k] = '0;
        hi[k] = '0;
      end
      for (e = 0; e < HALF_PIXELS; e++) begin
        // left, right, right reversed, left reversed
        pos[0] = e;
        pos[1] = e + HALF_PIXELS;
        pos[2] = ROW_PIXELS - 1 - e;
        pos[3] = HALF_PIXELS - 1 - e;
        for (k = 0; k < 4; k++) begin
          m2 = has2 && (px[pos[k]] == pal[2] + 1);
          if (m2) mixed = 1'b1;
          lo[k][7-e] = (px[pos[k]] == pal[0] + 1) || m2;
          hi[k][7-e] = (px[pos[k]] == pal[1] + 1) || m2;
        end
      end
      r.plane_a = lo[0];
      r.plane_b = lo[1];
      r.mirror_a = lo[2];
      r.mirror_b = lo[3];
      r.plane_c = hi[0];
      r.plane_d = hi[1];
      r.mirror_c = hi[2];
      r.mirror_d = hi[3];
      r.color_low = 8'(pal[0]);
      r.color_high = 8'(pal[1]) + (mixed ? MIX_FLAG : 8'd0);
      r.too_many = too;
    end
    return r;
  endfunction

  // one byte-wide view of field k, in the order of field_name
  function automatic logic [7:0] field_of(input row_code_t c, input int k);
    logic [87:0] w;
    w = c;
    if (k < 10) return w[8*k +: 8];
    if (k == 10) return {7'd0, w[80]};
    return {1'b0, w[87:81]};
  endfunction

  // mostly rows drawn from a small palette, often with the mixed colour in it;
  // the rest is raw noise over all 80 bits
  task automatic pick_row(output logic [79:0] pix, output logic mode);
    logic [4:0] pal [8];
    int         n_pal, blank_pct, mix_col, i;
    mode = ($urandom_range(99) < 75) ? MODE_MULTI : MODE_MONO;
    if ($urandom_range(99) < 12) begin
      pix = {16'($urandom), $urandom, $urandom};
    end else begin
      n_pal = $urandom_range(1, ($urandom_range(99) < 85) ? 4 : 8);
      for (i = 0; i < n_pal; i++) pal[i] = 5'($urandom_range(1, 31));
      if (n_pal >= 3 && $urandom_range(1) == 1) begin
        mix_col = (int'(pal[0]) - 1) | (int'(pal[1]) - 1);
        if (mix_col <= 30) pal[2] = 5'(mix_col + 1);
      end
      blank_pct = $urandom_range(0, 60);
      for (i = 0; i < ROW_PIXELS; i++) begin
        pix[PIX_BITS*i +: PIX_BITS] = ($urandom_range(99) < blank_pct) ?
            5'd0 : pal[$urandom_range(n_pal - 1)];
      end
    end
  endtask

  // present one row from a falling edge and hold it until the transfer
  task automatic send_row(input logic [79:0] pix, input logic mode, input logic known,
                          input row_code_t code);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= mode;
    probe_known <= known;
    probe_code <= code;
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver stalls at random outside the calm window
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // scoreboard: check the output transfer, then queue the code of the input
  // transfer of the same edge, then the watchdog
  always @(posedge clk) begin : scoreboard
    row_code_t got, want;
    int        k;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        n_codes++;
        if (pending_codes.size() == 0) begin
          n_errors++;
          if (n_reported < MAX_REPORTS) begin
            $display("unexpected output transfer %0d: %h", n_codes, got);
          end
          n_reported++;
        end else begin
          want = pending_codes.pop_front();
          for (k = 0; k < 12; k++) begin
            if (field_of(got, k) !== field_of(want, k)) begin
              n_errors++;
              if (n_reported < MAX_REPORTS) begin
                $display("row %0d %s: expected %02h, got %02h", n_codes,
                         field_name[k], field_of(want, k), field_of(got, k));
              end
              n_reported++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = probe_known ? probe_code : encode_row(s_tdata, s_tuser);
        pending_codes.push_back(want);
        n_rows++;
        if (s_tuser == MODE_MULTI) begin
          n_multi++;
          if (want.too_many) n_flagged++;
          if (want.color_high[6]) n_mixed++;
        end
      end
      // a stalled pipeline is a hang, not a slow run
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
          $display("timeout after %0d cycles with no transfer", idle_cycles);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [79:0] pix;
    logic        mode;
    int          i;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_PROBES; i++) begin
      send_row({probes[i].right, probes[i].left}, probes[i].mode, probes[i].known,
               row_code_t'({7'd0, probes[i].too, probes[i].chi, probes[i].clo,
                            {4{probes[i].mirrors}}, {4{probes[i].planes}}}));
    end

    for (i = 0; i < N_RANDOM; i++) begin
      calm = (i >= CALM_FIRST && i < CALM_LAST);
      pick_row(pix, mode);
      send_row(pix, mode, 1'b0, '0);
    end
    calm = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("encoded %0d rows, %0d in multicolour mode and %0d of those flagged as",
             n_rows, n_multi, n_flagged);
    $display("too many colours; %0d rows used the mixed colour", n_mixed);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sprpe_pkg.sv
hdl/sprpe_gather.sv
hdl/sprpe_fix.sv
hdl/sprpe_lane.sv
hdl/sprite_row_plane_encoder_mirrored_core.sv
bench/tb_sprite_row_plane_encoder_mirrored_core.sv
